// ===== sv/ctk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ctk_pkg;

  localparam int MaxTokens = 3;

  localparam logic [5:0] K_END      = 6'd0;
  localparam logic [5:0] K_IDENT    = 6'd1;
  localparam logic [5:0] K_INTCONST = 6'd2;
  localparam logic [5:0] K_STRING   = 6'd3;
  localparam logic [5:0] K_KW_FIRST = 6'd4;
  localparam logic [5:0] K_COMMA    = 6'd13;
  localparam logic [5:0] K_SEMI     = 6'd14;
  localparam logic [5:0] K_LBRACK   = 6'd15;
  localparam logic [5:0] K_RBRACK   = 6'd16;
  localparam logic [5:0] K_LBRACE   = 6'd17;
  localparam logic [5:0] K_RBRACE   = 6'd18;
  localparam logic [5:0] K_LPAREN   = 6'd19;
  localparam logic [5:0] K_RPAREN   = 6'd20;
  localparam logic [5:0] K_ASSIGN   = 6'd21;
  localparam logic [5:0] K_PLUS     = 6'd22;
  localparam logic [5:0] K_MINUS    = 6'd23;
  localparam logic [5:0] K_NOT      = 6'd24;
  localparam logic [5:0] K_STAR     = 6'd25;
  localparam logic [5:0] K_SLASH    = 6'd26;
  localparam logic [5:0] K_PERCENT  = 6'd27;
  localparam logic [5:0] K_LT       = 6'd28;
  localparam logic [5:0] K_GT       = 6'd29;
  localparam logic [5:0] K_LE       = 6'd30;
  localparam logic [5:0] K_GE       = 6'd31;
  localparam logic [5:0] K_EQ       = 6'd32;
  localparam logic [5:0] K_NE       = 6'd33;
  localparam logic [5:0] K_ANDAND   = 6'd34;
  localparam logic [5:0] K_OROR     = 6'd35;

  typedef struct packed {
    logic [5:0]  kind;
    logic [63:0] value;
    logic [31:0] start;
    logic [15:0] len;
  } tok_t;

  typedef struct packed {
    tok_t [MaxTokens-1:0] toks;
    logic [1:0]           cnt;
  } bundle_t;

endpackage
`default_nettype wire

// ===== sv/ctk_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface ctk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_file;
  modport source (output valid, ch, end_of_file, input ready);
  modport sink (input valid, ch, end_of_file, output ready);
endinterface

interface ctk_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         token_kind;
  logic signed [63:0] token_value;
  logic [31:0]        token_start;
  logic [15:0]        token_length;
  logic               last_of_run;
  modport source (output valid, token_kind, token_value, token_start, token_length,
                  last_of_run, input ready);
  modport sink (input valid, token_kind, token_value, token_start, token_length,
                last_of_run, output ready);
endinterface
`default_nettype wire

// ===== sv/ctk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctk_front import ctk_pkg::*; #(
  parameter int KEYWORD_MAX_CHARS = 8,
  parameter int POSITION_BITS     = 32,
  parameter int LENGTH_BITS       = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] ch_i,
  input  wire logic       eof_i,
  output bundle_t         bundle_o,
  output logic            push_o
);

  localparam int KIdx = (KEYWORD_MAX_CHARS > 1) ? $clog2(KEYWORD_MAX_CHARS) : 1;
  localparam logic [48:0] LenMaxX = (49'd1 << LENGTH_BITS) - 49'd1;

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_SLASH   = 4'd1;
  localparam logic [3:0] M_LINE    = 4'd2;
  localparam logic [3:0] M_BLOCK   = 4'd3;
  localparam logic [3:0] M_STAR    = 4'd4;
  localparam logic [3:0] M_IDENT   = 4'd5;
  localparam logic [3:0] M_ZERO    = 4'd6;
  localparam logic [3:0] M_NUM     = 4'd7;
  localparam logic [3:0] M_STRING  = 4'd8;
  localparam logic [3:0] M_OPFIRST = 4'd9;
  localparam logic [3:0] M_PAIR    = 4'd10;

  localparam logic [1:0] B_DEC = 2'd0;
  localparam logic [1:0] B_OCT = 2'd1;
  localparam logic [1:0] B_HEX = 2'd2;

  logic [3:0]               mode_q, mode_d;
  logic [7:0]               word_q [KEYWORD_MAX_CHARS];
  logic [7:0]               word_d [KEYWORD_MAX_CHARS];
  logic [1:0]               base_q, base_d;
  logic [63:0]              acc_q, acc_d;
  logic                     stop_q, stop_d;
  logic [POSITION_BITS-1:0] start_q, start_d;
  logic [LENGTH_BITS-1:0]   span_q, span_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     minus_q, minus_d;
  logic [POSITION_BITS-1:0] mpos_q, mpos_d;
  logic [7:0]               opc_q, opc_d;
  bundle_t                  bundle;

  function automatic tok_t mk_tok(logic [5:0] kind, logic [63:0] value, logic [31:0] start,
                                  logic [15:0] len);
    tok_t t;
    t.kind = kind;
    t.value = value;
    t.start = start;
    t.len = len;
    return t;
  endfunction

  function automatic bundle_t put(bundle_t b, tok_t t);
    bundle_t r;
    r = b;
    if (b.cnt != 2'd3) begin
      r.toks[b.cnt] = t;
      r.cnt = b.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic bundle_t emit_f(bundle_t b, logic m, tok_t mt, tok_t t);
    bundle_t r;
    r = b;
    if (m) begin
      r = put(r, mt);
    end
    r = put(r, t);
    return r;
  endfunction

  function automatic logic [15:0] sat16(logic [48:0] x);
    return (x > 49'hFFFF) ? 16'hFFFF : x[15:0];
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "+": k = K_PLUS;
      "*": k = K_STAR;
      "%": k = K_PERCENT;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ",": k = K_COMMA;
      ";": k = K_SEMI;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] single_op(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "<": k = K_LT;
      ">": k = K_GT;
      "!": k = K_NOT;
      default: k = K_ASSIGN;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] double_op(logic [7:0] c);
    logic [5:0] k;
    case (c)
      "<": k = K_LE;
      ">": k = K_GE;
      "!": k = K_NE;
      default: k = K_EQ;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] kw_text(int k);
    logic [63:0] s;
    case (k)
      0: s = 64'("int");
      1: s = 64'("const");
      2: s = 64'("void");
      3: s = 64'("if");
      4: s = 64'("else");
      5: s = 64'("while");
      6: s = 64'("break");
      7: s = 64'("continue");
      default: s = 64'("return");
    endcase
    return s;
  endfunction

  function automatic int kw_len(int k);
    int n;
    case (k)
      0: n = 3;
      1: n = 5;
      2: n = 4;
      3: n = 2;
      4: n = 4;
      5: n = 5;
      6: n = 5;
      7: n = 8;
      default: n = 6;
    endcase
    return n;
  endfunction

  // Keyword lookup runs on the stored word in parallel for all nine keywords.
  logic [5:0] id_kind;
  always_comb begin
    logic hit;
    logic [63:0] txt;
    id_kind = K_IDENT;
    for (int k = 0; k < 9; k++) begin
      txt = kw_text(k);
      hit = (32'(span_q) == 32'(kw_len(k)));
      for (int j = 0; j < 8; j++) begin
        if (j < kw_len(k) && word_q[j] != txt[8*(kw_len(k)-1-j) +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        id_kind = K_KW_FIRST + 6'(k);
      end
    end
  end

  logic [3:0]  dig_val;
  logic        dig_ok;
  logic        dig_fits;
  logic [63:0] acc_mul;

  always_comb begin
    dig_ok = 1'b1;
    dig_val = 4'd0;
    if (ch_i >= "0" && ch_i <= "9") begin
      dig_val = 4'(ch_i - "0");
    end else if (ch_i >= "a" && ch_i <= "f") begin
      dig_val = 4'(ch_i - "a" + 8'd10);
    end else if (ch_i >= "A" && ch_i <= "F") begin
      dig_val = 4'(ch_i - "A" + 8'd10);
    end else begin
      dig_ok = 1'b0;
    end
    case (base_q)
      B_HEX: begin
        dig_fits = 1'b1;
        acc_mul = acc_q << 4;
      end
      B_OCT: begin
        dig_fits = dig_val < 4'd8;
        acc_mul = acc_q << 3;
      end
      default: begin
        dig_fits = dig_val < 4'd10;
        acc_mul = (acc_q << 3) + (acc_q << 1);
      end
    endcase
  end

  logic [LENGTH_BITS-1:0]   span_inc;
  logic [POSITION_BITS-1:0] minus_dist;
  logic [48:0]              abs_len_x;
  logic [15:0]              abs_len;
  tok_t                     minus_tok;
  tok_t                     ident_tok;
  tok_t                     num_tok;
  tok_t                     neg_tok;
  logic                     absorb;

  assign span_inc   = (span_q != '1) ? span_q + LENGTH_BITS'(1) : span_q;
  assign minus_dist = pos_q - mpos_q;
  assign abs_len_x  = (49'(minus_dist) > LenMaxX) ? LenMaxX : 49'(minus_dist);
  assign abs_len    = sat16(abs_len_x);
  assign minus_tok  = mk_tok(K_MINUS, 64'd0, 32'(mpos_q), 16'd1);
  assign ident_tok  = mk_tok(id_kind, 64'd0, 32'(start_q), sat16(49'(span_q)));
  assign num_tok    = mk_tok(K_INTCONST, acc_q, 32'(start_q), sat16(49'(span_q)));
  assign neg_tok    = mk_tok(K_INTCONST, 64'd0 - acc_q, 32'(mpos_q), abs_len);
  assign absorb     = minus_q && (acc_q == 64'd2147483648);

  always_comb begin
    bundle_t b;
    logic m;
    logic do_idle;
    logic fin_num;
    b = '0;
    m = minus_q;
    do_idle = 1'b0;
    fin_num = 1'b0;
    mode_d = mode_q;
    word_d = word_q;
    base_d = base_q;
    acc_d = acc_q;
    stop_d = stop_q;
    start_d = start_q;
    span_d = span_q;
    pos_d = pos_q;
    mpos_d = mpos_q;
    opc_d = opc_q;

    if (eof_i) begin
      case (mode_q)
        M_SLASH: b = emit_f(b, m, minus_tok, mk_tok(K_SLASH, 64'd0, 32'(start_q), 16'd1));
        M_IDENT: b = emit_f(b, m, minus_tok, ident_tok);
        M_ZERO, M_NUM: fin_num = 1'b1;
        M_STRING: begin
          b = emit_f(b, m, minus_tok,
                     mk_tok(K_STRING, 64'd0, 32'(start_q), sat16(49'(span_q))));
        end
        M_OPFIRST: begin
          b = emit_f(b, m, minus_tok,
                     mk_tok(single_op(opc_q), 64'd0, 32'(start_q), 16'd1));
        end
        M_PAIR: begin
          b = emit_f(b, m, minus_tok, mk_tok((opc_q == "|") ? K_OROR : K_ANDAND, 64'd0,
                                             32'(start_q), 16'd1));
        end
        default: ;
      endcase
      if (mode_q == M_SLASH || mode_q == M_IDENT || mode_q == M_STRING ||
          mode_q == M_OPFIRST || mode_q == M_PAIR) begin
        m = 1'b0;
      end
      if (fin_num) begin
        if (absorb) begin
          b = put(b, neg_tok);
        end else begin
          b = emit_f(b, m, minus_tok, num_tok);
        end
        m = 1'b0;
      end
      if (m) begin
        b = put(b, minus_tok);
      end
      m = 1'b0;
      b = put(b, mk_tok(K_END, 64'd0, 32'(pos_q), 16'd0));
      mode_d = M_IDLE;
    end else begin
      pos_d = pos_q + POSITION_BITS'(1);
      case (mode_q)
        M_SLASH: begin
          if (ch_i == "/") begin
            mode_d = M_LINE;
          end else if (ch_i == "*") begin
            mode_d = M_BLOCK;
          end else begin
            b = emit_f(b, m, minus_tok, mk_tok(K_SLASH, 64'd0, 32'(start_q), 16'd1));
            m = 1'b0;
            do_idle = 1'b1;
          end
        end
        M_LINE: begin
          if (ch_i == 8'h0A) begin
            mode_d = M_IDLE;
          end
        end
        M_BLOCK: begin
          if (ch_i == "*") begin
            mode_d = M_STAR;
          end
        end
        M_STAR: begin
          if (ch_i == "/") begin
            mode_d = M_IDLE;
          end else if (ch_i != "*") begin
            mode_d = M_BLOCK;
          end
        end
        M_IDENT: begin
          if (is_letter(ch_i) || is_digit(ch_i)) begin
            if (32'(span_q) < 32'(KEYWORD_MAX_CHARS)) begin
              word_d[span_q[KIdx-1:0]] = ch_i;
            end
            span_d = span_inc;
          end else begin
            b = emit_f(b, m, minus_tok, ident_tok);
            m = 1'b0;
            do_idle = 1'b1;
          end
        end
        M_ZERO, M_NUM: begin
          if (mode_q == M_ZERO && (ch_i == "x" || ch_i == "X")) begin
            base_d = B_HEX;
            acc_d = 64'd0;
            span_d = span_inc;
            mode_d = M_NUM;
          end else begin
            mode_d = M_NUM;
            if (dig_ok) begin
              if (!stop_q) begin
                if (dig_fits) begin
                  acc_d = acc_mul + 64'(dig_val);
                end else begin
                  stop_d = 1'b1;
                end
              end
              span_d = span_inc;
            end else begin
              if (absorb) begin
                b = put(b, neg_tok);
              end else begin
                b = emit_f(b, m, minus_tok, num_tok);
              end
              m = 1'b0;
              do_idle = 1'b1;
            end
          end
        end
        M_STRING: begin
          span_d = span_inc;
          if (ch_i == "\"") begin
            b = emit_f(b, m, minus_tok,
                       mk_tok(K_STRING, 64'd0, 32'(start_q), sat16(49'(span_inc))));
            m = 1'b0;
            mode_d = M_IDLE;
          end
        end
        M_OPFIRST: begin
          if (ch_i == "=") begin
            b = emit_f(b, m, minus_tok,
                       mk_tok(double_op(opc_q), 64'd0, 32'(start_q), 16'd2));
            mode_d = M_IDLE;
          end else begin
            b = emit_f(b, m, minus_tok,
                       mk_tok(single_op(opc_q), 64'd0, 32'(start_q), 16'd1));
            do_idle = 1'b1;
          end
          m = 1'b0;
        end
        M_PAIR: begin
          b = emit_f(b, m, minus_tok, mk_tok((opc_q == "|") ? K_OROR : K_ANDAND, 64'd0,
                                             32'(start_q), 16'd2));
          m = 1'b0;
          mode_d = M_IDLE;
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_d = M_IDLE;
        if (ch_i == "/") begin
          mode_d = M_SLASH;
          start_d = pos_q;
        end else if (ch_i == "\"") begin
          mode_d = M_STRING;
          start_d = pos_q;
          span_d = LENGTH_BITS'(1);
        end else if (ch_i == "|" || ch_i == "&") begin
          mode_d = M_PAIR;
          opc_d = ch_i;
          start_d = pos_q;
        end else if (ch_i == "<" || ch_i == ">" || ch_i == "!" || ch_i == "=") begin
          mode_d = M_OPFIRST;
          opc_d = ch_i;
          start_d = pos_q;
        end else if (ch_i == "-") begin
          if (m) begin
            b = put(b, minus_tok);
          end
          m = 1'b1;
          mpos_d = pos_q;
        end else if (single_kind(ch_i) != K_END) begin
          b = emit_f(b, m, minus_tok, mk_tok(single_kind(ch_i), 64'd0, 32'(pos_q), 16'd1));
          m = 1'b0;
        end else if (is_letter(ch_i)) begin
          mode_d = M_IDENT;
          start_d = pos_q;
          span_d = LENGTH_BITS'(1);
          word_d[0] = ch_i;
        end else if (is_digit(ch_i)) begin
          start_d = pos_q;
          span_d = LENGTH_BITS'(1);
          acc_d = 64'(ch_i - "0");
          stop_d = 1'b0;
          base_d = (ch_i == "0") ? B_OCT : B_DEC;
          mode_d = (ch_i == "0") ? M_ZERO : M_NUM;
        end
      end
    end
    minus_d = m;
    bundle = b;
  end

  assign bundle_o = bundle;
  assign push_o = accept_i && (bundle.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      base_q  <= B_DEC;
      acc_q   <= 64'd0;
      stop_q  <= 1'b0;
      start_q <= '0;
      span_q  <= '0;
      pos_q   <= '0;
      minus_q <= 1'b0;
      mpos_q  <= '0;
      opc_q   <= 8'd0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      base_q  <= base_d;
      acc_q   <= acc_d;
      stop_q  <= stop_d;
      start_q <= start_d;
      span_q  <= span_d;
      pos_q   <= pos_d;
      minus_q <= minus_d;
      mpos_q  <= mpos_d;
      opc_q   <= opc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      word_q <= word_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ctk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctk_queue import ctk_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire bundle_t data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output bundle_t      data_o
);

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] count_q;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Push into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("Pop from an empty queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (wr_q == rd_q) |-> (count_q == 2'd0 || count_q == 2'd2))
    else $error("Queue pointers disagree with the fill count.");

endmodule
`default_nettype wire

// ===== sv/ctk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ctk_back import ctk_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire bundle_t q_data_i,
  output logic         q_pop_o,
  output logic         valid_o,
  input  wire logic    ready_i,
  output tok_t         tok_o,
  output logic         last_o
);

  bundle_t    cur_q;
  logic       have_q;
  logic [1:0] idx_q;
  logic       fire;
  logic       done;

  assign valid_o = have_q;
  assign tok_o   = cur_q.toks[idx_q];
  assign last_o  = idx_q == cur_q.cnt - 2'd1;
  assign fire    = have_q && ready_i;
  assign done    = !have_q || (fire && last_o);
  assign q_pop_o = done && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      idx_q <= 2'd0;
    end else if (q_pop_o) begin
      have_q <= 1'b1;
      idx_q <= 2'd0;
    end else if (done) begin
      have_q <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   have_q |-> (cur_q.cnt != 2'd0 && idx_q < cur_q.cnt))
    else $error("Token index outside the current group.");

endmodule
`default_nettype wire

// ===== sv/c_subset_char_tokenizer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Output path: the tokens of an accepted character are pushed into a two-group queue and
// then loaded into the output group register before the first of them becomes valid.
// Throughput: one character per cycle while the queue is not full; the output carries one
// token per cycle while the receiver is ready, so a character that yields n tokens sends them in turn.
// Reset: asynchronous and active low; the scanner returns to idle with all counts at zero,
// and no clearing pass is needed.
module c_subset_char_tokenizer import ctk_pkg::*; #(
  parameter int KEYWORD_MAX_CHARS = 8,
  parameter int POSITION_BITS     = 32,
  parameter int LENGTH_BITS       = 16
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  ctk_in_if.sink   in_i,
  ctk_out_if.source out_o
);

  logic    accept;
  logic    push;
  logic    full;
  logic    pop;
  logic    q_valid;
  bundle_t push_data;
  bundle_t q_data;
  tok_t    tok;
  logic    last;

  assign in_i.ready = !full;
  assign accept = in_i.valid && !full;

  ctk_front #(
    .KEYWORD_MAX_CHARS(KEYWORD_MAX_CHARS),
    .POSITION_BITS(POSITION_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .accept_i(accept),
    .ch_i(in_i.ch),
    .eof_i(in_i.end_of_file),
    .bundle_o(push_data),
    .push_o(push)
  );

  ctk_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(push_data),
    .full_o(full),
    .pop_i(pop),
    .valid_o(q_valid),
    .data_o(q_data)
  );

  ctk_back u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .q_valid_i(q_valid),
    .q_data_i(q_data),
    .q_pop_o(pop),
    .valid_o(out_o.valid),
    .ready_i(out_o.ready),
    .tok_o(tok),
    .last_o(last)
  );

  assign out_o.token_kind   = tok.kind;
  assign out_o.token_value  = tok.value;
  assign out_o.token_start  = tok.start;
  assign out_o.token_length = tok.len;
  assign out_o.last_of_run  = last;

endmodule
`default_nettype wire

// ===== tb/tb_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Expected-token record shared by the scoreboard and the top level.
package tb_tok_pkg;
  typedef struct {
    logic [5:0]  kind;
    logic [63:0] value;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } exp_tok_t;
endpackage
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import ctk_pkg::*;
  import tb_tok_pkg::*;

  localparam int IdleMode = 0, SlashMode = 1, LineMode = 2, BlockMode = 3, StarMode = 4;
  localparam int IdentMode = 5, ZeroMode = 6, NumMode = 7, StringMode = 8;
  localparam int OpFirstMode = 9, PairMode = 10;
  localparam int BaseDec = 0, BaseOct = 1, BaseHex = 2;
  localparam longint CycleLimit = 400000;

  class token_scoreboard;
    exp_tok_t pending[$];
    int errors;

    function void note(exp_tok_t t);
      pending = {pending, t};
    endfunction

    function void check(logic [5:0] k, logic [63:0] v, logic [31:0] s, logic [15:0] l,
                        logic lst);
      exp_tok_t e;
      if (pending.size() == 0) begin
        $error("token with no expectation: kind %0d", k);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $error("token_kind expected %0d actual %0d", e.kind, k); errors++;
      end
      if (v !== e.value) begin
        $error("token_value expected %0h actual %0h", e.value, v); errors++;
      end
      if (s !== e.start) begin
        $error("token_start expected %0d actual %0d", e.start, s); errors++;
      end
      if (l !== e.len) begin
        $error("token_length expected %0d actual %0d", e.len, l); errors++;
      end
      if (lst !== e.last) begin
        $error("last_of_run expected %0d actual %0d", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  ctk_in_if in_if();
  ctk_out_if out_if();

  c_subset_char_tokenizer DUT (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_if), .out_o(out_if));

  token_scoreboard board = new();
  longint cycles = 0;
  bit quiet = 0;
  bit hold_off = 0;

  // Scanner state mirrored for prediction.
  int mode;
  logic [7:0] word[8];
  int num_base;
  logic [63:0] accum;
  bit stopped;
  logic [31:0] span_pos;
  logic [15:0] span_len;
  logic [31:0] stream_pos;
  bit minus_held;
  logic [31:0] minus_pos;
  logic [7:0] op_char;
  exp_tok_t step_toks[$];

  function automatic void push_tok(logic [5:0] k, logic [63:0] v, logic [31:0] s,
                                   logic [15:0] l);
    exp_tok_t t;
    t.kind = k; t.value = v; t.start = s; t.len = l; t.last = 1'b0;
    step_toks = {step_toks, t};
  endfunction

  function automatic void release_minus();
    if (minus_held) begin
      push_tok(K_MINUS, 64'd0, minus_pos, 16'd1);
      minus_held = 0;
    end
  endfunction

  function automatic void emit_tok(logic [5:0] k, logic [63:0] v, logic [31:0] s,
                                   logic [15:0] l);
    release_minus();
    push_tok(k, v, s, l);
  endfunction

  function automatic void grow_span();
    if (span_len != 16'hFFFF) span_len++;
  endfunction

  function automatic bit letter(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_";
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void close_word();
    string kw[9] = '{"int", "const", "void", "if", "else", "while", "break", "continue",
                     "return"};
    logic [5:0] k;
    bit same;
    k = K_IDENT;
    for (int i = 0; i < 9; i++) begin
      if (span_len == kw[i].len()) begin
        same = 1;
        for (int j = 0; j < kw[i].len(); j++)
          if (word[j] != kw[i][j]) same = 0;
        if (same) k = K_KW_FIRST + 6'(i);
      end
    end
    emit_tok(k, 64'd0, span_pos, span_len);
  endfunction

  function automatic void close_number(logic [31:0] stop);
    logic [31:0] d;
    if (minus_held && accum == 64'd2147483648) begin
      d = stop - minus_pos;
      minus_held = 0;
      push_tok(K_INTCONST, 64'd0 - accum, minus_pos, d > 32'hFFFF ? 16'hFFFF : d[15:0]);
    end else begin
      emit_tok(K_INTCONST, accum, span_pos, span_len);
    end
  endfunction

  function automatic bit take_digit(logic [7:0] c);
    int d, lim;
    if (digit(c)) d = c - "0";
    else if (c >= "a" && c <= "f") d = c - "a" + 10;
    else if (c >= "A" && c <= "F") d = c - "A" + 10;
    else return 0;
    lim = num_base == BaseHex ? 16 : (num_base == BaseOct ? 8 : 10);
    if (!stopped) begin
      if (d < lim) accum = accum * lim + d;
      else stopped = 1;
    end
    grow_span();
    return 1;
  endfunction

  function automatic logic [5:0] lone_op(logic [7:0] c);
    case (c)
      "<": return K_LT;
      ">": return K_GT;
      "!": return K_NOT;
      default: return K_ASSIGN;
    endcase
  endfunction

  function automatic logic [5:0] twin_op(logic [7:0] c);
    case (c)
      "<": return K_LE;
      ">": return K_GE;
      "!": return K_NE;
      default: return K_EQ;
    endcase
  endfunction

  function automatic void start_char(logic [7:0] c, logic [31:0] p);
    logic [5:0] k;
    k = K_END;
    mode = IdleMode;
    case (c)
      "/": begin mode = SlashMode; span_pos = p; return; end
      "\"": begin mode = StringMode; span_pos = p; span_len = 1; return; end
      "|", "&": begin mode = PairMode; op_char = c; span_pos = p; return; end
      "<", ">", "!", "=": begin mode = OpFirstMode; op_char = c; span_pos = p; return; end
      "-": begin release_minus(); minus_held = 1; minus_pos = p; return; end
      "+": k = K_PLUS;
      "*": k = K_STAR;
      "%": k = K_PERCENT;
      "(": k = K_LPAREN;
      ")": k = K_RPAREN;
      "[": k = K_LBRACK;
      "]": k = K_RBRACK;
      "{": k = K_LBRACE;
      "}": k = K_RBRACE;
      ",": k = K_COMMA;
      ";": k = K_SEMI;
      default: ;
    endcase
    if (k != K_END) emit_tok(k, 64'd0, p, 16'd1);
    else if (letter(c)) begin
      mode = IdentMode; span_pos = p; span_len = 1; word[0] = c;
    end else if (digit(c)) begin
      span_pos = p; span_len = 1; accum = 64'(c - "0"); stopped = 0;
      num_base = c == "0" ? BaseOct : BaseDec;
      mode = c == "0" ? ZeroMode : NumMode;
    end
  endfunction

  function automatic void predict_char(logic [7:0] c, logic eof);
    logic [31:0] p;
    p = stream_pos;
    step_toks.delete();
    if (eof) begin
      case (mode)
        SlashMode: emit_tok(K_SLASH, 64'd0, span_pos, 16'd1);
        IdentMode: close_word();
        ZeroMode, NumMode: close_number(p);
        StringMode: emit_tok(K_STRING, 64'd0, span_pos, span_len);
        OpFirstMode: emit_tok(lone_op(op_char), 64'd0, span_pos, 16'd1);
        PairMode: emit_tok(op_char == "|" ? K_OROR : K_ANDAND, 64'd0, span_pos, 16'd1);
        default: ;
      endcase
      release_minus();
      push_tok(K_END, 64'd0, p, 16'd0);
      mode = IdleMode;
    end else begin
      case (mode)
        SlashMode:
          if (c == "/") mode = LineMode;
          else if (c == "*") mode = BlockMode;
          else begin emit_tok(K_SLASH, 64'd0, span_pos, 16'd1); start_char(c, p); end
        LineMode: if (c == 8'h0A) mode = IdleMode;
        BlockMode: if (c == "*") mode = StarMode;
        StarMode:
          if (c == "/") mode = IdleMode;
          else if (c != "*") mode = BlockMode;
        IdentMode:
          if (letter(c) || digit(c)) begin
            if (span_len < 8) word[span_len] = c;
            grow_span();
          end else begin
            close_word(); start_char(c, p);
          end
        ZeroMode:
          if (c == "x" || c == "X") begin
            num_base = BaseHex; accum = 0; grow_span(); mode = NumMode;
          end else begin
            mode = NumMode;
            if (!take_digit(c)) begin close_number(p); start_char(c, p); end
          end
        NumMode: if (!take_digit(c)) begin close_number(p); start_char(c, p); end
        StringMode: begin
          grow_span();
          if (c == "\"") begin
            emit_tok(K_STRING, 64'd0, span_pos, span_len); mode = IdleMode;
          end
        end
        OpFirstMode:
          if (c == "=") begin
            emit_tok(twin_op(op_char), 64'd0, span_pos, 16'd2); mode = IdleMode;
          end else begin
            emit_tok(lone_op(op_char), 64'd0, span_pos, 16'd1); start_char(c, p);
          end
        PairMode: begin
          emit_tok(op_char == "|" ? K_OROR : K_ANDAND, 64'd0, span_pos, 16'd2);
          mode = IdleMode;
        end
        default: start_char(c, p);
      endcase
      stream_pos = p + 1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) board.note(step_toks[i]);
  endfunction

  initial begin
    in_if.valid = 1'b0;
    in_if.ch = 8'd0;
    in_if.end_of_file = 1'b0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      board.check(out_if.token_kind, out_if.token_value, out_if.token_start,
                  out_if.token_length, out_if.last_of_run);
    out_if.ready <= !hold_off && (quiet || $urandom_range(99) >= 19);
  end

  task automatic send(logic [7:0] c, logic eof);
    in_if.valid <= 1'b1;
    in_if.ch <= c;
    in_if.end_of_file <= eof;
    do @(posedge clk_i); while (!in_if.ready);
    predict_char(c, eof);
    while (!quiet && $urandom_range(99) < 19) begin
      in_if.valid <= 1'b0;
      in_if.ch <= 8'($urandom);
      @(posedge clk_i);
    end
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  function automatic string random_lexeme();
    string pool[] = '{"int", "const", "void", "if", "else", "while", "break", "continue",
                      "return", "x_1", "Abc9", "0x1F", "0X", "017", "089", "2147483648",
                      "-2147483648", "- 2147483648", "-5", "\"ab c\"", "\"\"", "/* a **/",
                      "// c\n", "/", "<=", ">=", "==", "!=", "<", ">", "!", "=", "&&", "||",
                      "&x", "|\n", "+", "*", "%", "(", ")", "[", "]", "{", "}", ",", ";",
                      ":", " ", "\n", "99999999999999999999999", "0xffffffffffffffff1",
                      "1a", "0xg", "a+b", "x[3]=y-1;"};
    return pool[$urandom_range(pool.size() - 1)];
  endfunction

  initial begin
    int sent;
    mode = IdleMode; num_base = BaseDec; accum = 0; stopped = 0; span_pos = 0; span_len = 0;
    stream_pos = 0; minus_held = 0; minus_pos = 0; op_char = 0;
    foreach (word[i]) word[i] = 8'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    quiet = 1;
    send_text("int x=0x1fG; -2147483648 \"s\" /**/ a&&b||c<=>=!=== 0777 09 ");
    send(8'hFF, 1'b0);
    send(8'h00, 1'b0);
    send_text("0x -");
    send(8'd0, 1'b1);
    send_text("\"open");
    send(8'hA5, 1'b1);
    send_text("/* end");
    send(8'd0, 1'b1);
    send_text("|");
    send(8'd0, 1'b1);
    quiet = 0;
    wait_drained();

    hold_off = 1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_off = 0;
      end
      send_text("+-*%(){}[],;a b c d e f g h i j k l m n o p");
    join
    wait_drained();

    sent = 0;
    while (sent < 180) begin
      if (sent > 60 && sent < 110) quiet = 1;
      else quiet = 0;
      if ($urandom_range(99) < 15) begin
        send(8'($urandom), 1'b0);
        sent++;
      end else if ($urandom_range(99) < 3) begin
        send(8'($urandom), 1'b1);
        sent++;
      end else begin
        string s;
        s = random_lexeme();
        send_text(s);
        sent += s.len();
      end
    end
    send(8'd0, 1'b1);
    quiet = 0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
